FILE: src/plhsm_pkg.sv
// ----------------------------------------------------------------------------
// plhsm_pkg: shared types and constants of the hot slot manager
// Operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package plhsm_pkg;

	// Default sizes handed to the top level parameters
	localparam int SLOT_COUNT_DEF = 64;
	localparam int PIN_BITS_DEF   = 8;

	// Fixed field widths
	localparam int GEN_W   = 32;
	localparam int STAMP_W = 64;
	localparam int HOT_W   = 7;
	localparam int SLOT_W  = 6;

	// Most release items one trim may report
	localparam int RESULT_LIMIT = 64;

	// Capacity after reset
	localparam logic [HOT_W-1:0] CAP_RESET = 7'd8;

	typedef enum logic [1:0] {
		FN_PIN      = 2'd0,
		FN_UNPIN    = 2'd1,
		FN_TRIM     = 2'd2,
		FN_VALIDATE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_BUSY      = 2'd1,
		STS_UNDERFLOW = 2'd2,
		STS_STALE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_PICK,
		S_FINISH,
		S_REPLY,
		S_TRIM_END
	} state_t;

endpackage

FILE: src/plhsm_ifs.sv
// ----------------------------------------------------------------------------
// plhsm_ifs: channel interfaces of the hot slot manager
// Request, response and capacity write channels, valid/ready handshake.
// ----------------------------------------------------------------------------

interface plhsm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [5:0]  slot;
	logic [31:0] generation;

	modport source (output valid, output func, output slot, output generation, input ready);
	modport sink (input valid, input func, input slot, input generation, output ready);
endinterface

interface plhsm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        released_valid;
	logic [5:0]  released_slot;
	logic [31:0] released_generation;
	logic [6:0]  hot_total;
	logic        last;

	modport source (output valid, output status, output released_valid,
		output released_slot, output released_generation, output hot_total,
		output last, input ready);
	modport sink (input valid, input status, input released_valid,
		input released_slot, input released_generation, input hot_total,
		input last, output ready);
endinterface

interface plhsm_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] cap_limit;

	modport source (output valid, output cap_limit, input ready);
	modport sink (input valid, input cap_limit, output ready);
endinterface

FILE: src/pinned_lru_hot_slot_manager.sv
// ----------------------------------------------------------------------------
// pinned_lru_hot_slot_manager: hot set manager with pinning and LRU eviction
// Slot table in one memory, walked by a small sequencer with a single
// compare unit for victim search and trim.
// ----------------------------------------------------------------------------
// Channel | Dir | Carries
// --------+-----+----------------------------------------------------------
// req     | in  | func, slot, generation
// rsp     | out | status, released_valid/slot/generation, hot_total, last
// cfg     | in  | cap_limit (always ready)
//
// Validate and unpin pass through EVAL and REPLY, a pin that needs no eviction
// through EVAL, FINISH and REPLY, a slot index out of range straight to REPLY.
// A pin into a full hot set and a trim walk the slot table one entry per cycle
// through the memory read port, unless a held trim result stalls the walk.
// After reset a clearing pass writes every entry; req is not ready meanwhile.
// A stalled rsp holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module pinned_lru_hot_slot_manager
	import plhsm_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int PIN_BITS   = PIN_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	plhsm_req_if.sink    req,
	plhsm_rsp_if.source  rsp,
	plhsm_cfg_if.sink    cfg
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W = GEN_W + STAMP_W + PIN_BITS + 1;
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	function automatic logic [HOT_W-1:0] hot_dec(input logic [HOT_W-1:0] h);
		hot_dec = (h == '0) ? h : h - 1'b1;
	endfunction

	function automatic logic [HOT_W-1:0] hot_inc(input logic [HOT_W-1:0] h);
		hot_inc = (h == '1) ? h : h + 1'b1;
	endfunction

	state_t state_q, state_d;

	// Control registers
	logic [HOT_W-1:0]   cap_q;
	logic [HOT_W-1:0]   hot_q;
	logic [STAMP_W-1:0] use_q;
	logic [CNT_W-1:0]   scan_q;
	logic               vld_s1;
	logic               found_q;
	logic               mk_hot_q;
	logic               pend_q;
	logic [HOT_W-1:0]   n_q;
	logic               ov_q;

	// Payload registers
	func_t              func_q;
	logic [GEN_W-1:0]   gen_q;
	logic [IDX_W-1:0]   sidx_q;
	status_t            res_status_q;
	logic [GEN_W-1:0]   ent_gen_q;
	logic [STAMP_W-1:0] ent_stamp_q;
	logic [PIN_BITS-1:0] ent_pins_q;
	logic               ent_hot_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [GEN_W-1:0]   vic_gen_q;
	logic [STAMP_W-1:0] vic_stamp_q;
	logic [IDX_W-1:0]   idx_s1;
	logic [SLOT_W-1:0]  pend_idx_q;
	logic [GEN_W-1:0]   pend_gen_q;
	logic [HOT_W-1:0]   pend_tot_q;
	status_t            o_status_q;
	logic               o_rel_q;
	logic [SLOT_W-1:0]  o_slot_q;
	logic [GEN_W-1:0]   o_gen_q;
	logic [HOT_W-1:0]   o_tot_q;
	logic               o_last_q;

	// Memory port signals
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENT_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENT_W-1:0]   ram_rdata;

	// Entry fields of the read data
	logic [GEN_W-1:0]    rd_gen;
	logic [STAMP_W-1:0]  rd_stamp;
	logic [PIN_BITS-1:0] rd_pins;
	logic                rd_hot;

	logic accept, out_free, in_range_in, is_trim;
	logic gen_diff, rst_hot, pin_zero;
	logic [HOT_W-1:0] hot_rst;
	logic cand_v, cand_t, take_t, stall, issue, scan_done;
	logic ld_reply, ld_tend, ld_pend;
	logic [PIN_BITS-1:0] pins_inc;

	plhsm_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Split the entry: {generation, stamp, pins, hot}
	assign rd_gen   = ram_rdata[ENT_W-1 -: GEN_W];
	assign rd_stamp = ram_rdata[PIN_BITS+1 +: STAMP_W];
	assign rd_pins  = ram_rdata[PIN_BITS:1];
	assign rd_hot   = ram_rdata[0];

	// Handshake terms
	assign accept      = req.valid && req.ready;
	assign out_free    = !ov_q || rsp.ready;
	assign in_range_in = 32'(req.slot) < SLOT_COUNT;
	assign is_trim     = (func_q == FN_TRIM);

	// Generation check of the looked-up slot
	assign gen_diff = (rd_gen != gen_q);
	assign rst_hot  = gen_diff ? 1'b0 : rd_hot;
	assign hot_rst  = (gen_diff && rd_hot) ? hot_dec(hot_q) : hot_q;
	assign pin_zero = (rd_pins == '0);

	// Shared compare unit of the table walk
	assign cand_v = rd_hot && pin_zero && (idx_s1 != sidx_q)
		&& (!found_q || (rd_stamp < vic_stamp_q));
	assign cand_t = rd_hot && pin_zero && (n_q < HOT_W'(RESULT_LIMIT));
	assign stall  = (state_q == S_SCAN) && vld_s1 && is_trim && cand_t
		&& pend_q && !out_free;
	assign take_t = (state_q == S_SCAN) && vld_s1 && is_trim && cand_t && !stall;
	assign issue  = (scan_q < CNT_W'(SLOT_COUNT)) && !stall;
	assign scan_done = (scan_q == CNT_W'(SLOT_COUNT)) && !vld_s1;

	assign pins_inc = (ent_pins_q == PIN_MAX) ? ent_pins_q : ent_pins_q + 1'b1;

	// Output register loads
	assign ld_reply = (state_q == S_REPLY) && out_free;
	assign ld_tend  = (state_q == S_TRIM_END) && out_free;
	assign ld_pend  = take_t && pend_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (scan_q == CNT_W'(SLOT_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (func_t'(req.func) == FN_TRIM) state_d = S_SCAN;
					else if (!in_range_in) state_d = S_REPLY;
					else state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (func_q != FN_PIN) state_d = S_REPLY;
				else if (rst_hot) state_d = S_FINISH;
				else if (hot_rst >= cap_q) state_d = S_SCAN;
				else state_d = S_FINISH;
			end
			S_SCAN: begin
				if (scan_done) state_d = is_trim ? S_TRIM_END : S_PICK;
			end
			S_PICK: begin
				state_d = found_q ? S_FINISH : S_REPLY;
			end
			S_FINISH: begin
				state_d = S_REPLY;
			end
			S_REPLY, S_TRIM_END: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memory port and ready
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = sidx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = scan_q[IDX_W-1:0];
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = scan_q[IDX_W-1:0];
			end
			S_IDLE: begin
				req.ready = 1'b1;
				ram_re    = accept;
				ram_raddr = IDX_W'(req.slot);
			end
			S_EVAL: begin
				// Drop one pin on unpin
				if (func_q == FN_UNPIN && !pin_zero) begin
					ram_we    = 1'b1;
					ram_wdata = {rd_gen, rd_stamp, rd_pins - 1'b1, rd_hot};
				end
			end
			S_SCAN: begin
				ram_re = issue;
				// Cool a trimmed slot
				if (take_t) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1;
					ram_wdata = {rd_gen, rd_stamp, rd_pins, 1'b0};
				end
			end
			S_PICK: begin
				ram_we = 1'b1;
				if (found_q) begin
					ram_waddr = vic_idx_q;
					ram_wdata = {vic_gen_q, vic_stamp_q, {PIN_BITS{1'b0}}, 1'b0};
				end else begin
					ram_wdata = {ent_gen_q, ent_stamp_q, ent_pins_q, ent_hot_q};
				end
			end
			S_FINISH: begin
				ram_we    = 1'b1;
				ram_wdata = {ent_gen_q, use_q + 1'b1, pins_inc, ent_hot_q | mk_hot_q};
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cap_q    <= CAP_RESET;
			hot_q    <= '0;
			use_q    <= '0;
			scan_q   <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			mk_hot_q <= 1'b0;
			pend_q   <= 1'b0;
			n_q      <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) cap_q <= cfg.cap_limit;

			if (ld_reply || ld_tend || ld_pend) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					scan_q <= scan_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						scan_q   <= '0;
						vld_s1   <= 1'b0;
						found_q  <= 1'b0;
						mk_hot_q <= 1'b0;
						pend_q   <= 1'b0;
						n_q      <= '0;
					end
				end
				S_EVAL: begin
					if (func_q == FN_PIN) begin
						hot_q <= hot_rst;
						if (!rst_hot && hot_rst < cap_q) mk_hot_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (issue) scan_q <= scan_q + 1'b1;
					vld_s1 <= issue || stall;
					if (vld_s1 && !is_trim && cand_v) found_q <= 1'b1;
					if (take_t) begin
						pend_q <= 1'b1;
						n_q    <= n_q + 1'b1;
						hot_q  <= hot_dec(hot_q);
					end
				end
				S_PICK: begin
					if (found_q) begin
						hot_q    <= hot_dec(hot_q);
						mk_hot_q <= 1'b1;
					end
				end
				S_FINISH: begin
					use_q <= use_q + 1'b1;
					if (mk_hot_q) hot_q <= hot_inc(hot_q);
				end
				default: begin
				end
			endcase
		end
	end

	// Item, entry and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q       <= func_t'(req.func);
					gen_q        <= req.generation;
					sidx_q       <= IDX_W'(req.slot);
					res_status_q <= STS_STALE;
				end
			end
			S_EVAL: begin
				case (func_q)
					FN_VALIDATE: res_status_q <= gen_diff ? STS_STALE : STS_OK;
					FN_UNPIN:    res_status_q <= pin_zero ? STS_UNDERFLOW : STS_OK;
					default:     res_status_q <= STS_OK;
				endcase
				// Reset the slot on a generation change
				ent_gen_q   <= gen_q;
				ent_stamp_q <= gen_diff ? '0 : rd_stamp;
				ent_pins_q  <= gen_diff ? '0 : rd_pins;
				ent_hot_q   <= rst_hot;
			end
			S_SCAN: begin
				if (!stall) idx_s1 <= scan_q[IDX_W-1:0];
				if (vld_s1 && !is_trim && cand_v) begin
					vic_idx_q   <= idx_s1;
					vic_gen_q   <= rd_gen;
					vic_stamp_q <= rd_stamp;
				end
				if (take_t) begin
					pend_idx_q <= SLOT_W'(idx_s1);
					pend_gen_q <= rd_gen;
					pend_tot_q <= hot_dec(hot_q);
				end
			end
			S_PICK: begin
				if (!found_q) res_status_q <= STS_BUSY;
			end
			default: begin
			end
		endcase

		// Load the output register
		if (ld_reply) begin
			o_status_q <= res_status_q;
			o_rel_q    <= found_q;
			o_slot_q   <= found_q ? SLOT_W'(vic_idx_q) : '0;
			o_gen_q    <= found_q ? vic_gen_q : '0;
			o_tot_q    <= hot_q;
			o_last_q   <= 1'b1;
		end else if (ld_tend) begin
			o_status_q <= STS_OK;
			o_rel_q    <= pend_q;
			o_slot_q   <= pend_q ? pend_idx_q : '0;
			o_gen_q    <= pend_q ? pend_gen_q : '0;
			o_tot_q    <= pend_q ? pend_tot_q : hot_q;
			o_last_q   <= 1'b1;
		end else if (ld_pend) begin
			o_status_q <= STS_OK;
			o_rel_q    <= 1'b1;
			o_slot_q   <= pend_idx_q;
			o_gen_q    <= pend_gen_q;
			o_tot_q    <= pend_tot_q;
			o_last_q   <= 1'b0;
		end
	end

	// Drive the ports
	assign cfg.ready               = 1'b1;
	assign rsp.valid               = ov_q;
	assign rsp.status              = o_status_q;
	assign rsp.released_valid      = o_rel_q;
	assign rsp.released_slot       = o_slot_q;
	assign rsp.released_generation = o_gen_q;
	assign rsp.hot_total           = o_tot_q;
	assign rsp.last                = o_last_q;

endmodule

FILE: src/plhsm_ram.sv
// ----------------------------------------------------------------------------
// plhsm_ram: generic single write, single read memory
// One write port, one read port with registered read data held while idle.
// ----------------------------------------------------------------------------
module plhsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/plhsm_checker.sv
// ----------------------------------------------------------------------------
// plhsm_checker: port-level checks of the hot slot manager
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module plhsm_checker
	import plhsm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic        rsp_released_valid,
	input logic [5:0]  rsp_released_slot,
	input logic [31:0] rsp_released_generation,
	input logic        rsp_last
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_released_slot) && $stable(rsp_released_generation)
			&& $stable(rsp_last))
		else $error("stalled result changed");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while busy");

	// A release always reports ok
	a_rel_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_released_valid |-> rsp_status == STS_OK)
		else $error("release with non-ok status");

	// Only trim releases come before the final result
	a_mid_release: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_released_valid)
		else $error("non-final result without release");

	// No release fields without a release
	a_rel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_released_valid |-> rsp_released_slot == '0
			&& rsp_released_generation == '0)
		else $error("release fields set without release");

endmodule

bind pinned_lru_hot_slot_manager plhsm_checker u_plhsm_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.req_valid              (req.valid),
	.req_ready              (req.ready),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_status             (rsp.status),
	.rsp_released_valid     (rsp.released_valid),
	.rsp_released_slot      (rsp.released_slot),
	.rsp_released_generation(rsp.released_generation),
	.rsp_last               (rsp.last)
);
